FILE: design/bfqs_pkg.sv
`default_nettype none

package bfqs_pkg;

  // item codes on in_mode
  localparam logic [1:0] MODE_FILL  = 2'd0;
  localparam logic [1:0] MODE_PIXEL = 2'd1;
  localparam logic [1:0] MODE_SCAN  = 2'd2;

  // one-hot sequencer states
  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_FILL     = 4'b0010,
    ST_PIX_WR   = 4'b0100,
    ST_SCAN_OUT = 4'b1000
  } state_t;

  localparam logic [7:0] BYTE_ONES = 8'hff;

endpackage

`default_nettype wire

FILE: design/bitpacked_framebuffer_quarter_scan_unit.sv
`default_nettype none

// Monochrome frame store, one bit per pixel, eight pixels per byte with the
// leftmost pixel in bit 7, rows stored top to bottom.
// Input channel: a transaction is taken on a rising edge with start high and
// busy low. in_mode selects fill screen, draw one pixel or read one scan byte.
// Result channel: out_valid is high for exactly one cycle with out_scan_byte;
// the receiver cannot stall, so the byte must be taken in that cycle.
// Config channel: cfg_ready is always high; cfg_negative_polarity is written
// on cfg_valid and is meant to change only while the block is idle.
// Transaction flow, all set by the single port of the byte store:
//   scan read: result in the cycle after acceptance; the next transaction may
//     be accepted in that result cycle, so scans run one per cycle
//   pixel draw: a read, then a write back; busy during the write
//   off-screen pixel or unused mode: no store write, busy stays low
//   fill: busy while one byte of the store is written per cycle
// Reset: the store (256 bytes at the default size) is cleared by a pass
// with busy high; config writes are taken anyway.
module bitpacked_framebuffer_quarter_scan_unit #(
  parameter int SCREEN_COLUMNS = 64,
  parameter int SCREEN_ROWS    = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_mode,
  input  wire logic signed [15:0] in_x_coord,
  input  wire logic signed [15:0] in_y_coord,
  input  wire logic               in_pixel_value,
  input  wire logic [1:0]         in_scan_part,
  input  wire logic [5:0]         in_scan_index,
  output logic                    out_valid,
  output logic [7:0]              out_scan_byte,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_negative_polarity
);

  localparam int ROW_BYTES   = (SCREEN_COLUMNS + 7) / 8;
  localparam int STORE_BYTES = ROW_BYTES * SCREEN_ROWS;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam int YW          = $clog2(SCREEN_ROWS);

  // scan lookup: index {part, index}, top bit marks an in-range position
  typedef logic [AW:0] scan_tab_t [256];

  function automatic scan_tab_t build_scan_tab();
    scan_tab_t tab;
    int        per_part;
    int        col;
    int        step;
    int        row;
    for (int p = 0; p < 4; p++) begin
      per_part = (SCREEN_ROWS + p) / 4;
      col      = 0;
      step     = 0;
      for (int i = 0; i < 64; i++) begin
        if (per_part != 0 && col < ROW_BYTES) begin
          row            = SCREEN_ROWS - 4 + p - 4 * step;
          tab[p * 64 + i] = {1'b1, AW'(row * ROW_BYTES + col)};
        end else begin
          tab[p * 64 + i] = '0;
        end
        step = step + 1;
        if (step == per_part) begin
          step = 0;
          col  = col + 1;
        end
      end
    end
    return tab;
  endfunction

  localparam scan_tab_t SCAN_TAB = build_scan_tab();

  bfqs_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]    fill_cnt_r, fill_cnt_nxt;
  logic [7:0]       fill_val_r, fill_val_nxt;
  logic [AW-1:0]    pix_addr_r, pix_addr_nxt;
  logic [7:0]       pix_mask_r, pix_mask_nxt;
  logic             pix_set_r, pix_set_nxt;
  logic             scan_zero_r, scan_zero_nxt;
  logic             polarity_r;

  logic          accept;
  logic [15:0]   x_u;
  logic [15:0]   y_u;
  logic          pix_on_screen;
  logic [AW-1:0] pix_addr;
  logic [AW:0]   scan_entry;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rd_data;

  // handshake
  assign busy      = !(state_r == bfqs_pkg::ST_IDLE || state_r == bfqs_pkg::ST_SCAN_OUT);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // polarity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      polarity_r <= 1'b0;
    end else if (cfg_valid) begin
      polarity_r <= cfg_negative_polarity;
    end
  end

  // pixel address and bounds
  assign x_u           = $unsigned(in_x_coord);
  assign y_u           = $unsigned(in_y_coord);
  assign pix_on_screen = !x_u[15] && !y_u[15] &&
                         (x_u < 16'(SCREEN_COLUMNS)) && (y_u < 16'(SCREEN_ROWS));
  assign pix_addr      = AW'(y_u[YW-1:0]) * AW'(ROW_BYTES) + AW'(x_u >> 3);

  // scan position lookup
  assign scan_entry = SCAN_TAB[{in_scan_part, in_scan_index}];

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    fill_cnt_nxt  = fill_cnt_r;
    fill_val_nxt  = fill_val_r;
    pix_addr_nxt  = pix_addr_r;
    pix_mask_nxt  = pix_mask_r;
    pix_set_nxt   = pix_set_r;
    scan_zero_nxt = scan_zero_r;
    mem_we        = 1'b0;
    mem_wdata     = fill_val_r;
    mem_addr      = scan_entry[AW-1:0];
    case (state_r)
      bfqs_pkg::ST_FILL: begin
        mem_we       = 1'b1;
        mem_addr     = fill_cnt_r;
        fill_cnt_nxt = fill_cnt_r + 1'b1;
        if (fill_cnt_r == AW'(STORE_BYTES - 1)) begin
          state_nxt = bfqs_pkg::ST_IDLE;
        end
      end
      bfqs_pkg::ST_PIX_WR: begin
        mem_we    = 1'b1;
        mem_addr  = pix_addr_r;
        mem_wdata = pix_set_r ? (mem_rd_data | pix_mask_r) : (mem_rd_data & ~pix_mask_r);
        state_nxt = bfqs_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = bfqs_pkg::ST_IDLE;
        if (accept) begin
          case (in_mode)
            bfqs_pkg::MODE_FILL: begin
              state_nxt    = bfqs_pkg::ST_FILL;
              fill_cnt_nxt = '0;
              fill_val_nxt = in_pixel_value ? bfqs_pkg::BYTE_ONES : 8'h00;
            end
            bfqs_pkg::MODE_PIXEL: begin
              mem_addr     = pix_addr;
              pix_addr_nxt = pix_addr;
              pix_mask_nxt = 8'h80 >> x_u[2:0];
              pix_set_nxt  = in_pixel_value ^ polarity_r;
              if (pix_on_screen) begin
                state_nxt = bfqs_pkg::ST_PIX_WR;
              end
            end
            bfqs_pkg::MODE_SCAN: begin
              mem_addr      = scan_entry[AW-1:0];
              scan_zero_nxt = !scan_entry[AW];
              state_nxt     = bfqs_pkg::ST_SCAN_OUT;
            end
            default: begin
              state_nxt = bfqs_pkg::ST_IDLE;
            end
          endcase
        end
      end
    endcase
  end

  // control state; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= bfqs_pkg::ST_FILL;
      fill_cnt_r <= '0;
      fill_val_r <= 8'h00;
    end else begin
      state_r    <= state_nxt;
      fill_cnt_r <= fill_cnt_nxt;
      fill_val_r <= fill_val_nxt;
    end
  end

  // per-transaction payload
  always_ff @(posedge clk) begin
    pix_addr_r  <= pix_addr_nxt;
    pix_mask_r  <= pix_mask_nxt;
    pix_set_r   <= pix_set_nxt;
    scan_zero_r <= scan_zero_nxt;
  end

  bfqs_store #(
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .we      (mem_we),
    .addr    (mem_addr),
    .wdata   (mem_wdata),
    .rd_data (mem_rd_data)
  );

  // result strobe
  assign out_valid     = (state_r == bfqs_pkg::ST_SCAN_OUT);
  assign out_scan_byte = scan_zero_r ? 8'h00 : mem_rd_data;

endmodule

`default_nettype wire

FILE: design/bfqs_store.sv
`default_nettype none

module bfqs_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [7:0]    wdata,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  // single port byte store, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rd_data <= mem[addr];
  end

endmodule

`default_nettype wire

FILE: design/bfqs_checker.sv
`default_nettype none

module bfqs_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] in_mode,
  input wire logic       out_valid,
  input wire logic       cfg_ready
);

  logic accept;
  assign accept = start && !busy;

  // a result only follows an accepted scan read
  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(rst_n) && $past(accept && in_mode == bfqs_pkg::MODE_SCAN))
    else $error("result without a scan read transaction");

  // every accepted scan read gives a result next cycle
  a_scan_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_mode == bfqs_pkg::MODE_SCAN) |=> out_valid)
    else $error("scan read transaction lost");

  // clearing pass holds off input right after reset
  a_reset_clears: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> busy)
    else $error("input open during clearing pass");

  // a fill keeps the block busy
  a_fill_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_mode == bfqs_pkg::MODE_FILL) |=> busy)
    else $error("fill transaction did not occupy the block");

  // config channel never stalls
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config channel stalled");

endmodule

bind bitpacked_framebuffer_quarter_scan_unit bfqs_checker u_bfqs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_mode   (in_mode),
  .out_valid (out_valid),
  .cfg_ready (cfg_ready)
);

`default_nettype wire

FILE: test/tb_bitpacked_framebuffer_quarter_scan_unit.sv
`default_nettype none

module tb_bitpacked_framebuffer_quarter_scan_unit;

  localparam int SCREEN_COLUMNS = 64;
  localparam int SCREEN_ROWS    = 32;
  localparam int ROW_BYTES      = (SCREEN_COLUMNS + 7) / 8;
  localparam int STORE_BYTES    = ROW_BYTES * SCREEN_ROWS;
  localparam int DRAIN_CYCLES   = STORE_BYTES + 50;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int RANDOM_PER_PHASE = 170;
  localparam int DIRECTED_ROWS  = 24;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // one input transaction plus an optional typed-in scan byte
  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] x_coord;
    logic [15:0] y_coord;
    logic        pixel_value;
    logic [1:0]  scan_part;
    logic [5:0]  scan_index;
    logic        pinned;
    logic [7:0]  pinned_byte;
  } item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_mode = bfqs_pkg::MODE_FILL;
  logic signed [15:0] in_x_coord = '0;
  logic signed [15:0] in_y_coord = '0;
  logic in_pixel_value = 1'b0;
  logic [1:0] in_scan_part = '0;
  logic [5:0] in_scan_index = '0;
  logic out_valid;
  logic [7:0] out_scan_byte;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_negative_polarity = 1'b0;

  // typed-in expectation travels with the transaction
  logic pin_valid = 1'b0;
  logic [7:0] pin_byte = '0;

  // shadow copy of the frame store and the polarity register
  logic [7:0] shadow_store [STORE_BYTES];
  logic shadow_polarity;
  logic [7:0] scan_bytes_due [$];
  int mismatches = 0;
  int cycle_count = 0;

  item_t directed_rows [DIRECTED_ROWS];

  bitpacked_framebuffer_quarter_scan_unit #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS(SCREEN_ROWS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_mode(in_mode),
    .in_x_coord(in_x_coord),
    .in_y_coord(in_y_coord),
    .in_pixel_value(in_pixel_value),
    .in_scan_part(in_scan_part),
    .in_scan_index(in_scan_index),
    .out_valid(out_valid),
    .out_scan_byte(out_scan_byte),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_negative_polarity(cfg_negative_polarity)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // set or clear one pixel, off-screen coordinates leave the store alone
  function automatic void plot_pixel(input logic signed [15:0] x, input logic signed [15:0] y,
                                     input logic value);
    int xi;
    int yi;
    int addr;
    xi = x;
    yi = y;
    if (xi < 0 || yi < 0 || xi >= SCREEN_COLUMNS || yi >= SCREEN_ROWS) return;
    addr = yi * ROW_BYTES + xi / 8;
    shadow_store[addr][7 - (xi % 8)] = value ^ shadow_polarity;
  endfunction

  // byte fetched by the four-part interleaved scan
  function automatic logic [7:0] scan_fetch(input logic [1:0] part, input logic [5:0] index);
    int rows_per_part;
    int col;
    int row;
    rows_per_part = (SCREEN_ROWS + int'(part)) / 4;
    if (rows_per_part == 0) return 8'h00;
    col = int'(index) / rows_per_part;
    if (col >= ROW_BYTES) return 8'h00;
    row = SCREEN_ROWS - 4 + int'(part) - 4 * (int'(index) % rows_per_part);
    if (row < 0 || row >= SCREEN_ROWS) return 8'h00;
    return shadow_store[row * ROW_BYTES + col];
  endfunction

  task automatic flag_mismatch(input string what, input logic [7:0] want, input logic [7:0] got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch, %s: expected %02h, got %02h", what, want, got);
  endtask

  // result check first, then predict for the transaction taken at this edge
  always @(posedge clk) begin : monitor
    logic [7:0] want;
    if (rst_n && $isunknown(out_valid)) flag_mismatch("out_valid unknown", 8'h00, 8'h00);
    if (rst_n && out_valid === 1'b1) begin
      if (scan_bytes_due.size() == 0) begin
        flag_mismatch("result with nothing pending", 8'h00, out_scan_byte);
      end else begin
        want = scan_bytes_due.pop_front();
        if (out_scan_byte !== want) flag_mismatch("scan_byte", want, out_scan_byte);
      end
    end
    if (rst_n && cfg_valid && cfg_ready) shadow_polarity = cfg_negative_polarity;
    if (rst_n && start && busy === 1'b0) begin
      case (in_mode)
        bfqs_pkg::MODE_FILL: begin
          foreach (shadow_store[i]) begin
            shadow_store[i] = in_pixel_value ? bfqs_pkg::BYTE_ONES : 8'h00;
          end
        end
        bfqs_pkg::MODE_PIXEL: begin
          plot_pixel(in_x_coord, in_y_coord, in_pixel_value);
        end
        bfqs_pkg::MODE_SCAN: begin
          scan_bytes_due.push_back(pin_valid ? pin_byte : scan_fetch(in_scan_part, in_scan_index));
        end
        default: ;
      endcase
    end
  end

  // present one transaction after an optional gap, return at the accepting edge
  task automatic drive_item(input item_t it, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_mode <= it.mode;
    in_x_coord <= it.x_coord;
    in_y_coord <= it.y_coord;
    in_pixel_value <= it.pixel_value;
    in_scan_part <= it.scan_part;
    in_scan_index <= it.scan_index;
    pin_valid <= it.pinned;
    pin_byte <= it.pinned_byte;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // drain, let a fill run out, then write the polarity register
  task automatic set_polarity(input logic value);
    start <= 1'b0;
    while (scan_bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_negative_polarity <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
  endtask

  // mostly on-screen pixels and scans, some edges, fills, unused mode and wild coordinates
  function automatic item_t random_item();
    item_t it;
    int pick;
    int where;
    it = '0;
    it.pixel_value = 1'($urandom_range(1));
    it.scan_part = 2'($urandom_range(3));
    it.scan_index = 6'($urandom_range(63));
    where = $urandom_range(9);
    if (where < 7) begin
      it.x_coord = 16'($urandom_range(SCREEN_COLUMNS - 1));
      it.y_coord = 16'($urandom_range(SCREEN_ROWS - 1));
    end else if (where < 8) begin
      it.x_coord = 16'($urandom_range(SCREEN_COLUMNS + 2) - 2);
      it.y_coord = 16'($urandom_range(SCREEN_ROWS + 2) - 2);
    end else begin
      it.x_coord = 16'($urandom);
      it.y_coord = 16'($urandom);
    end
    pick = $urandom_range(99);
    if (pick < 3) it.mode = bfqs_pkg::MODE_FILL;
    else if (pick < 8) it.mode = MODE_UNUSED;
    else if (pick < 50) it.mode = bfqs_pkg::MODE_PIXEL;
    else it.mode = bfqs_pkg::MODE_SCAN;
    return it;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 6);
  endfunction

  task automatic run_random(input int count);
    int gap;
    int calm_left;
    calm_left = 0;
    for (int n = 0; n < count; n++) begin
      // occasional back-to-back stretches
      if (calm_left == 0 && $urandom_range(9) == 0) calm_left = $urandom_range(60, 20);
      if (calm_left > 0) begin
        gap = 0;
        calm_left--;
      end else begin
        gap = pick_gap();
      end
      drive_item(random_item(), gap);
    end
  endtask

  // cycle limit
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    foreach (shadow_store[i]) shadow_store[i] = 8'h00;
    shadow_polarity = 1'b0;

    // mode, x, y, value, part, index, pinned, pinned byte
    directed_rows = '{
      // store is clear after reset
      '{bfqs_pkg::MODE_SCAN,  16'd0,    16'd0,    1'b0, 2'd0, 6'd0,  1'b1, 8'h00},
      '{bfqs_pkg::MODE_SCAN,  16'd0,    16'd0,    1'b0, 2'd3, 6'd63, 1'b1, 8'h00},
      '{bfqs_pkg::MODE_FILL,  16'd0,    16'd0,    1'b1, 2'd0, 6'd0,  1'b0, 8'h00},
      '{bfqs_pkg::MODE_SCAN,  16'd0,    16'd0,    1'b0, 2'd1, 6'd17, 1'b1, 8'hff},
      // top-left and bottom-right corners
      '{bfqs_pkg::MODE_PIXEL, 16'd0,    16'd0,    1'b0, 2'd0, 6'd0,  1'b0, 8'h00},
      '{bfqs_pkg::MODE_SCAN,  16'd0,    16'd0,    1'b0, 2'd0, 6'd7,  1'b1, 8'h7f},
      '{bfqs_pkg::MODE_PIXEL, 16'd63,   16'd31,   1'b0, 2'd0, 6'd0,  1'b0, 8'h00},
      '{bfqs_pkg::MODE_SCAN,  16'd0,    16'd0,    1'b0, 2'd3, 6'd56, 1'b1, 8'hfe},
      // off-screen pixels
      '{bfqs_pkg::MODE_PIXEL, 16'hffff, 16'd0,    1'b0, 2'd0, 6'd0,  1'b0, 8'h00},
      '{bfqs_pkg::MODE_PIXEL, 16'd64,   16'd0,    1'b0, 2'd0, 6'd0,  1'b0, 8'h00},
      '{bfqs_pkg::MODE_PIXEL, 16'd0,    16'd32,   1'b0, 2'd0, 6'd0,  1'b0, 8'h00},
      '{bfqs_pkg::MODE_PIXEL, 16'h8000, 16'h8000, 1'b0, 2'd0, 6'd0,  1'b0, 8'h00},
      '{bfqs_pkg::MODE_PIXEL, 16'h7fff, 16'h7fff, 1'b0, 2'd0, 6'd0,  1'b0, 8'h00},
      // unused mode looks like a clearing pixel but must do nothing
      '{MODE_UNUSED,          16'd8,    16'd0,    1'b0, 2'd3, 6'd63, 1'b0, 8'h00},
      '{bfqs_pkg::MODE_SCAN,  16'd0,    16'd0,    1'b0, 2'd0, 6'd7,  1'b0, 8'h00},
      '{bfqs_pkg::MODE_SCAN,  16'd0,    16'd0,    1'b0, 2'd0, 6'd15, 1'b0, 8'h00},
      '{bfqs_pkg::MODE_SCAN,  16'd0,    16'd0,    1'b0, 2'd1, 6'd8,  1'b0, 8'h00},
      '{bfqs_pkg::MODE_PIXEL, 16'd5,    16'd10,   1'b0, 2'd0, 6'd0,  1'b0, 8'h00},
      '{bfqs_pkg::MODE_SCAN,  16'd0,    16'd0,    1'b0, 2'd2, 6'd5,  1'b0, 8'h00},
      // clear fill, then set a pixel in a cleared store
      '{bfqs_pkg::MODE_FILL,  16'd0,    16'd0,    1'b0, 2'd0, 6'd0,  1'b0, 8'h00},
      '{bfqs_pkg::MODE_SCAN,  16'd0,    16'd0,    1'b0, 2'd2, 6'd40, 1'b1, 8'h00},
      '{bfqs_pkg::MODE_PIXEL, 16'd7,    16'd3,    1'b1, 2'd0, 6'd0,  1'b0, 8'h00},
      '{bfqs_pkg::MODE_SCAN,  16'd0,    16'd0,    1'b0, 2'd3, 6'd7,  1'b0, 8'h00},
      '{bfqs_pkg::MODE_SCAN,  16'd0,    16'd0,    1'b0, 2'd1, 6'd0,  1'b0, 8'h00}
    };

    // reset
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    set_polarity(1'b0);

    // directed table
    for (int r = 0; r < DIRECTED_ROWS; r++) drive_item(directed_rows[r], $urandom_range(2));

    // random phases across polarity settings
    set_polarity(1'b1);
    run_random(RANDOM_PER_PHASE);
    set_polarity(1'b0);
    run_random(RANDOM_PER_PHASE);
    set_polarity(1'b1);
    run_random(RANDOM_PER_PHASE);

    // drain
    start <= 1'b0;
    while (scan_bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
